// ===== sv/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
// No dependencies; every other file in this block imports this package.
package cau_pkg;

    // Word width of every real and imaginary part.
    localparam int XLEN = 32;
    // Quotient and root bits, one per iterative stage.
    localparam int QW = 32;
    // Default number of fractional bits.
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MAG = 3'd4,
        CMD_EQ  = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [XLEN-1:0] MAX_S = 32'h7FFF_FFFF;
    localparam logic [XLEN-1:0] MIN_S = 32'h8000_0000;

    // Per-item side information that travels beside the iterative stages.
    typedef struct packed {
        cmd_t            cmd;
        logic [XLEN-1:0] res_re;
        logic [XLEN-1:0] res_im;
        logic            eq;
        logic            sat;
        logic            neg_re;
        logic            neg_im;
        logic            ovf_re;
        logic            ovf_im;
        logic            dz;
    } side_t;

endpackage

// ===== sv/cau_front.sv =====
// Front end of the complex arithmetic unit: products, sums, add/sub/mul results.
// Three register stages. Depends on cau_pkg.
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [2:0]                 command,
    input  logic signed [31:0]         a_re,
    input  logic signed [31:0]         a_im,
    input  logic signed [31:0]         b_re,
    input  logic signed [31:0]         b_im,
    output logic                       side_valid,
    output cau_pkg::side_t             side,
    output logic [63:0]                num_re_mag,
    output logic [63:0]                num_im_mag,
    output logic [63:0]                sq
);
    import cau_pkg::*;

    // Stage 1 registers.
    logic               v1_reg;
    cmd_t               cmd1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_xx_reg, p_yy_reg;
    logic [31:0]        as_re_reg, as_im_reg;
    logic               as_sat_reg, eq1_reg;

    // Stage 2 registers.
    logic               v2_reg;
    cmd_t               cmd2_reg;
    logic signed [64:0] re_sum_reg, im_sum_reg;
    logic [63:0]        sq2_reg;
    logic [31:0]        as_re2_reg, as_im2_reg;
    logic               as_sat2_reg, eq2_reg;

    // Stage 3 registers.
    logic               v3_reg;
    side_t              side3_reg;
    logic [63:0]        mag_re_reg, mag_im_reg, sq3_reg;

    // Stage 1 next values.
    cmd_t               cmd1_next;
    logic signed [31:0] sq_x, sq_y;
    logic signed [32:0] sum_re, sum_im;
    logic [31:0]        as_re_next, as_im_next;
    logic               as_sat_next;

    // Stage 2 and 3 next values.
    logic               is_div2;
    logic signed [64:0] re_sum_next, im_sum_next;
    logic [63:0]        sq2_next;
    logic signed [64:0] sh_re, sh_im;
    logic [31:0]        mul_re, mul_im;
    logic               mul_sat;
    logic [63:0]        mag_re_next, mag_im_next;
    side_t              side3_next;

    // Operand selection for the squares: magnitude of a, or |b|^2 otherwise.
    always_comb
    begin
        cmd1_next = cmd_t'(command);
        if (cmd1_next == CMD_MAG)
        begin
            sq_x = a_re;
            sq_y = a_im;
        end
        else
        begin
            sq_x = b_re;
            sq_y = b_im;
        end
    end

    // Add and subtract with saturation.
    always_comb
    begin
        if (cmd1_next == CMD_SUB)
        begin
            sum_re = {a_re[31], a_re} - {b_re[31], b_re};
            sum_im = {a_im[31], a_im} - {b_im[31], b_im};
        end
        else
        begin
            sum_re = {a_re[31], a_re} + {b_re[31], b_re};
            sum_im = {a_im[31], a_im} + {b_im[31], b_im};
        end
        as_sat_next = 1'b0;
        as_re_next  = sum_re[31:0];
        as_im_next  = sum_im[31:0];
        if (sum_re[32] != sum_re[31])
        begin
            as_sat_next = 1'b1;
            as_re_next  = sum_re[32] ? MIN_S : MAX_S;
        end
        if (sum_im[32] != sum_im[31])
        begin
            as_sat_next = 1'b1;
            as_im_next  = sum_im[32] ? MIN_S : MAX_S;
        end
    end

    // Valid bits of all front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 payload: the six products, the add/sub results and the equality flag.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg   <= cmd1_next;
            p_rr_reg   <= a_re * b_re;
            p_ii_reg   <= a_im * b_im;
            p_ri_reg   <= a_re * b_im;
            p_ir_reg   <= a_im * b_re;
            p_xx_reg   <= sq_x * sq_x;
            p_yy_reg   <= sq_y * sq_y;
            as_re_reg  <= as_re_next;
            as_im_reg  <= as_im_next;
            as_sat_reg <= as_sat_next;
            eq1_reg    <= (a_re == b_re) && (a_im == b_im);
        end
    end

    // Stage 2: exact sums of products, for multiply or for divide.
    always_comb
    begin
        is_div2 = (cmd1_reg == CMD_DIV);
        if (is_div2)
        begin
            re_sum_next = 65'(p_rr_reg) + 65'(p_ii_reg);
            im_sum_next = 65'(p_ir_reg) - 65'(p_ri_reg);
        end
        else
        begin
            re_sum_next = 65'(p_rr_reg) - 65'(p_ii_reg);
            im_sum_next = 65'(p_ir_reg) + 65'(p_ri_reg);
        end
        sq2_next = p_xx_reg + p_yy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd2_reg    <= cmd1_reg;
            re_sum_reg  <= re_sum_next;
            im_sum_reg  <= im_sum_next;
            sq2_reg     <= sq2_next;
            as_re2_reg  <= as_re_reg;
            as_im2_reg  <= as_im_reg;
            as_sat2_reg <= as_sat_reg;
            eq2_reg     <= eq1_reg;
        end
    end

    // Stage 3: floor shift and clamp for multiply.
    always_comb
    begin
        sh_re   = re_sum_reg >>> FRAC_BITS;
        sh_im   = im_sum_reg >>> FRAC_BITS;
        mul_sat = 1'b0;
        mul_re  = sh_re[31:0];
        mul_im  = sh_im[31:0];
        if (sh_re > 65'sh0_7FFF_FFFF)
        begin
            mul_sat = 1'b1;
            mul_re  = MAX_S;
        end
        else if (sh_re < -65'sh0_8000_0000)
        begin
            mul_sat = 1'b1;
            mul_re  = MIN_S;
        end
        if (sh_im > 65'sh0_7FFF_FFFF)
        begin
            mul_sat = 1'b1;
            mul_im  = MAX_S;
        end
        else if (sh_im < -65'sh0_8000_0000)
        begin
            mul_sat = 1'b1;
            mul_im  = MIN_S;
        end
    end

    // Stage 3: divide preparation and the result of add, subtract, multiply and compare.
    always_comb
    begin
        logic [64:0] neg_re_v, neg_im_v;
        neg_re_v    = -re_sum_reg;
        neg_im_v    = -im_sum_reg;
        mag_re_next = re_sum_reg[64] ? neg_re_v[63:0] : re_sum_reg[63:0];
        mag_im_next = im_sum_reg[64] ? neg_im_v[63:0] : im_sum_reg[63:0];

        side3_next        = '0;
        side3_next.cmd    = cmd2_reg;
        side3_next.neg_re = re_sum_reg[64];
        side3_next.neg_im = im_sum_reg[64];
        // A quotient of 2^32 or more always saturates.
        side3_next.ovf_re = (96'(mag_re_next) << FRAC_BITS) >= {sq2_reg, 32'd0};
        side3_next.ovf_im = (96'(mag_im_next) << FRAC_BITS) >= {sq2_reg, 32'd0};
        side3_next.dz     = (sq2_reg == 64'd0);
        case (cmd2_reg)
            CMD_ADD, CMD_SUB:
            begin
                side3_next.res_re = as_re2_reg;
                side3_next.res_im = as_im2_reg;
                side3_next.sat    = as_sat2_reg;
            end
            CMD_MUL:
            begin
                side3_next.res_re = mul_re;
                side3_next.res_im = mul_im;
                side3_next.sat    = mul_sat;
            end
            CMD_EQ:
            begin
                side3_next.eq = eq2_reg;
            end
            default:
            begin
                side3_next.res_re = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg  <= side3_next;
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            sq3_reg    <= sq2_reg;
        end
    end

    assign side_valid = v3_reg;
    assign side       = side3_reg;
    assign num_re_mag = mag_re_reg;
    assign num_im_mag = mag_im_reg;
    assign sq         = sq3_reg;

endmodule

// ===== sv/cau_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Computes floor(mag * 2^FRAC_BITS / den) for quotients below 2^32. Depends on cau_pkg.
module cau_div_pipe #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [63:0]            mag,
    input  logic [63:0]            den,
    output logic [cau_pkg::QW-1:0] quo
);
    import cau_pkg::*;

    logic [63:0]   r_reg   [QW];
    logic [63:0]   d_reg   [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] q_reg   [QW];

    logic [63:0]   r_first;
    logic [QW-1:0] lo_first;

    // Upper dividend bits start the remainder; the lower ones are shifted in.
    assign r_first  = mag >> (QW - FRAC_BITS);
    assign lo_first = mag[QW-1:0] << FRAC_BITS;

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [63:0]   r_prev, d_prev, r_next;
        logic [QW-1:0] lo_prev, q_prev;
        logic [64:0]   r_sh, r_sub;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_prev  = r_first;
            assign d_prev  = den;
            assign lo_prev = lo_first;
            assign q_prev  = '0;
        end
        else
        begin : g_rest
            assign r_prev  = r_reg[k-1];
            assign d_prev  = d_reg[k-1];
            assign lo_prev = lo_reg[k-1];
            assign q_prev  = q_reg[k-1];
        end

        // One trial subtraction.
        always_comb
        begin
            r_sh   = {r_prev, lo_prev[QW-1]};
            r_sub  = r_sh - {1'b0, d_prev};
            ge     = (r_sh >= {1'b0, d_prev});
            r_next = ge ? r_sub[63:0] : r_sh[63:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]  <= r_next;
                d_reg[k]  <= d_prev;
                lo_reg[k] <= {lo_prev[QW-2:0], 1'b0};
                q_reg[k]  <= {q_prev[QW-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ===== sv/cau_sqrt_pipe.sv =====
// Pipelined integer square root: one root bit per register stage.
// Computes floor(sqrt(s)) of a 64-bit value. Depends on cau_pkg.
module cau_sqrt_pipe (
    input  logic                   clk,
    input  logic                   en,
    input  logic [63:0]            s,
    output logic [cau_pkg::QW-1:0] root
);
    import cau_pkg::*;

    logic [63:0]   s_reg    [QW];
    logic [33:0]   rem_reg  [QW];
    logic [QW-1:0] root_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [63:0]   s_prev;
        logic [33:0]   rem_prev, rem_next;
        logic [QW-1:0] root_prev;
        logic [35:0]   rem_sh, trial, rem_sub;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign s_prev    = s;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign s_prev    = s_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        // Bring down two bits and try root*4+1.
        always_comb
        begin
            rem_sh   = {rem_prev, s_prev[63:62]};
            trial    = {2'b00, root_prev, 2'b01};
            rem_sub  = rem_sh - trial;
            ge       = (rem_sh >= trial);
            rem_next = ge ? rem_sub[33:0] : rem_sh[33:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k]    <= {s_prev[61:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_prev[QW-2:0], ge};
            end
        end
    end

    assign root = root_reg[QW-1];

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, two dividers, square root, output.
// Depends on cau_pkg, cau_front, cau_div_pipe and cau_sqrt_pipe.
//
//   Channel  Handshake              Fields
//   input    in_valid / in_ready    command, a_re, a_im, b_re, b_im
//   output   out_valid / out_ready  res_re, res_im, equal, status
//
// One item enters per cycle while the pipeline is not frozen; every command passes through three front stages
// (products, sums, scaling), 32 divider and square-root stages at one bit each, and
// the output register. Reset clears only the valid bits. When the output holds a result
// that is not taken, the whole pipeline freezes and in_ready is low.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               equal,
    output logic [1:0]         status
);
    import cau_pkg::*;

    logic          en;
    logic          f_valid;
    side_t         f_side;
    logic [63:0]   mag_re, mag_im, sq;
    logic [QW-1:0] q_re, q_im, root;

    logic          vld_reg  [QW];
    side_t         side_reg [QW];

    logic          out_valid_reg;
    logic [31:0]   res_re_reg, res_im_reg;
    logic          equal_reg;
    logic [1:0]    status_reg;

    side_t         sd;
    logic [32:0]   div_re, div_im;
    logic [31:0]   res_re_next, res_im_next;
    logic          equal_next;
    logic [1:0]    status_next;
    logic          sat_next;

    // Global advance: move when the output is empty or being taken.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .command    (command),
        .a_re       (a_re),
        .a_im       (a_im),
        .b_re       (b_re),
        .b_im       (b_im),
        .side_valid (f_valid),
        .side       (f_side),
        .num_re_mag (mag_re),
        .num_im_mag (mag_im),
        .sq         (sq)
    );

    cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk (clk),
        .en  (en),
        .mag (mag_re),
        .den (sq),
        .quo (q_re)
    );

    cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk (clk),
        .en  (en),
        .mag (mag_im),
        .den (sq),
        .quo (q_im)
    );

    cau_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (en),
        .s    (sq),
        .root (root)
    );

    // Side information delay line, aligned with the iterative stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= f_valid;
            for (int i = 1; i < QW; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= f_side;
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Signed quotient with saturation; returns {saturated, value}.
    function automatic logic [32:0] quo_to32(input logic neg, input logic ovf,
                                             input logic [QW-1:0] q);
        logic [32:0] r;
        if (ovf)
        begin
            r = {1'b1, neg ? MIN_S : MAX_S};
        end
        else if (!neg)
        begin
            r = (q > MAX_S) ? {1'b1, MAX_S} : {1'b0, q};
        end
        else
        begin
            r = (q > MIN_S) ? {1'b1, MIN_S} : {1'b0, 32'(0 - q)};
        end
        return r;
    endfunction

    // Final result selection.
    always_comb
    begin
        sd          = side_reg[QW-1];
        div_re      = quo_to32(sd.neg_re, sd.ovf_re, q_re);
        div_im      = quo_to32(sd.neg_im, sd.ovf_im, q_im);
        res_re_next = sd.res_re;
        res_im_next = sd.res_im;
        equal_next  = sd.eq;
        sat_next    = sd.sat;
        status_next = ST_OK;
        case (sd.cmd)
            CMD_DIV:
            begin
                if (sd.dz)
                begin
                    res_re_next = '0;
                    res_im_next = '0;
                    sat_next    = 1'b0;
                end
                else
                begin
                    res_re_next = div_re[31:0];
                    res_im_next = div_im[31:0];
                    sat_next    = div_re[32] | div_im[32];
                end
            end
            CMD_MAG:
            begin
                sat_next    = (root > MAX_S);
                res_re_next = sat_next ? MAX_S : root;
                res_im_next = '0;
            end
            default:
            begin
                sat_next = sd.sat;
            end
        endcase
        if (sd.cmd == CMD_DIV && sd.dz)
        begin
            status_next = ST_DZ;
        end
        else if (sat_next)
        begin
            status_next = ST_SAT;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            equal_reg  <= equal_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign equal     = equal_reg;
    assign status    = status_reg;

endmodule
